/* hdl/sv39ptw_pkg.sv */
package sv39ptw_pkg;

  localparam int VA_W       = 39;
  localparam int PPN_W      = 44;
  localparam int PA_W       = 56;
  localparam int FLAG_W     = 10;
  localparam int IDX_W      = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int WADDR_W    = 12;
  localparam int PTE_W      = 64;

  // pte layout
  localparam int PTE_V_BIT   = 0;
  localparam int PTE_PPN_LSB = 10;

  // request kinds
  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // walk depth, top level index field first
  localparam int LEVELS = 3;
  localparam logic [1:0] TOP_LVL   = 2'd2;
  localparam logic [1:0] FINAL_LVL = 2'(3 - LEVELS);

  typedef struct packed {
    logic               req_type;
    logic [WADDR_W-1:0] word_addr;
    logic [PTE_W-1:0]   word_data;
    logic [VA_W-1:0]    virt_addr;
  } walk_req_t;

  typedef struct packed {
    logic              mapped;
    logic [PA_W-1:0]   phys_addr;
    logic [FLAG_W-1:0] leaf_flags;
  } walk_rsp_t;

  typedef struct packed {
    logic start_walk;   // latch va, read top-level entry
    logic write_word;   // store one table word
    logic step_walk;    // follow current entry to next level
    logic load_result;  // load result from current entry
    logic load_ack;     // load all-zero write acknowledge
  } ptw_cmd_t;

  typedef struct packed {
    logic entry_valid;
    logic last_level;
  } ptw_status_t;

endpackage

/* hdl/sv39ptw_ctrl.sv */
module sv39ptw_ctrl
  import sv39ptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_req_type,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  ptw_status_t status,
  output ptw_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_WALK      = 2'd1;
  localparam logic [1:0] ST_HOLD_WALK = 2'd2;
  localparam logic [1:0] ST_HOLD_ACK  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       accept;
  logic       walk_done;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign walk_done = !status.entry_valid || status.last_level;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_TRANSLATE) begin
            cmd.start_walk = 1'b1;
            state_next     = ST_WALK;
          end else begin
            cmd.write_word = 1'b1;
            if (out_free) begin
              cmd.load_ack = 1'b1;
            end else begin
              state_next = ST_HOLD_ACK;
            end
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          if (out_free) begin
            cmd.load_result = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            state_next = ST_HOLD_WALK;
          end
        end else begin
          cmd.step_walk = 1'b1;
        end
      end
      ST_HOLD_WALK: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_HOLD_ACK: begin
        if (out_free) begin
          cmd.load_ack = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result || cmd.load_ack) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_result || cmd.load_ack) |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken result");

  // waiting states are only entered behind a stalled result
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD_WALK || state == ST_HOLD_ACK) |-> out_valid)
    else $error("holding a result while the output register is free");

  // a new result only appears through a load
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(cmd.load_result || cmd.load_ack))
    else $error("result valid without a load");

  // a walk step never follows a finished walk
  a_step_walking: assert property (@(posedge clk) disable iff (rst)
    cmd.step_walk |-> (state == ST_WALK && status.entry_valid))
    else $error("walk step outside an active walk");

endmodule

/* hdl/sv39ptw_dp.sv */
module sv39ptw_dp
  import sv39ptw_pkg::*;
#(
  parameter int TABLE_WORDS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [PPN_W-1:0]  cfg_wdata,
  input  walk_req_t         in_data,
  input  ptw_cmd_t          cmd,
  output ptw_status_t       status,
  output walk_rsp_t         out_data
);

  localparam int AW = $clog2(TABLE_WORDS);

  logic [PTE_W-1:0] table_mem [TABLE_WORDS];

  logic [PPN_W-1:0] root_ppn;
  logic [VA_W-1:0]  va;
  logic [1:0]       lvl;
  logic [1:0]       lvl_next;
  logic [PTE_W-1:0] entry;
  logic [PPN_W-1:0] entry_ppn;
  logic [PPN_W-1:0] rd_ppn;
  logic [IDX_W-1:0] rd_idx;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;

  function automatic logic [IDX_W-1:0] vpn_index(input logic [VA_W-1:0] v,
                                                 input logic [1:0] l);
    logic [IDX_W-1:0] r;
    case (l)
      2'd0:    r = v[PAGE_SHIFT +: IDX_W];
      2'd1:    r = v[PAGE_SHIFT + IDX_W +: IDX_W];
      default: r = v[PAGE_SHIFT + 2*IDX_W +: IDX_W];
    endcase
    return r;
  endfunction

  assign entry_ppn = entry[PTE_PPN_LSB +: PPN_W];
  assign lvl_next  = lvl - 2'd1;

  // first read from the root page, later reads from the entry just fetched
  always_comb begin
    if (cmd.start_walk) begin
      rd_ppn = root_ppn;
      rd_idx = vpn_index(in_data.virt_addr, TOP_LVL);
    end else begin
      rd_ppn = entry_ppn;
      rd_idx = vpn_index(va, lvl_next);
    end
  end

  assign rd_addr = AW'({rd_ppn, rd_idx});
  assign wr_addr = AW'(in_data.word_addr);
  assign rd_en   = cmd.start_walk || cmd.step_walk;

  always_ff @(posedge clk) begin
    if (cmd.write_word) begin
      table_mem[wr_addr] <= in_data.word_data;
    end
    if (rd_en) begin
      entry <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_ppn <= '0;
    end else if (cfg_wen) begin
      root_ppn <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      va  <= in_data.virt_addr;
      lvl <= TOP_LVL;
    end else if (cmd.step_walk) begin
      lvl <= lvl_next;
    end
  end

  assign status.entry_valid = entry[PTE_V_BIT];
  assign status.last_level  = (lvl == FINAL_LVL);

  always_ff @(posedge clk) begin
    if (cmd.load_ack) begin
      out_data <= '0;
    end else if (cmd.load_result) begin
      if (entry[PTE_V_BIT]) begin
        out_data.mapped     <= 1'b1;
        out_data.phys_addr  <= {entry_ppn, va[PAGE_SHIFT-1:0]};
        out_data.leaf_flags <= entry[FLAG_W-1:0];
      end else begin
        out_data <= '0;
      end
    end
  end

  // the walk never steps past the final level
  a_no_overstep: assert property (@(posedge clk) disable iff (rst)
    cmd.step_walk |-> (lvl != FINAL_LVL))
    else $error("walk stepped past the final level");

  // a walk read and a table write never share a cycle
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && cmd.write_word))
    else $error("table read and write in the same cycle");

  // the level counter starts at the top after a walk begins
  a_lvl_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_walk |=> (lvl == TOP_LVL))
    else $error("walk did not start at the top level");

endmodule

/* hdl/sv39_page_table_walker.sv */
// channel   dir  handshake             payload
// cfg       in   cfg_wen               cfg_wdata   root table page number
// in        in   in_valid / in_stall   in_data     write word or translate request
// out       out  out_valid / out_stall out_data    acknowledge or translation
//
// a table write is stored when taken, its acknowledge loads once the output is free
// a translation reads the top-level entry on issue, then one level after another up
// to the final level or an invalid entry, set by the dependent reads of the table
// the result sits in an output register, so a new request is taken while it waits
// reset clears the controller, the output valid flag and the root page number;
// the table store and result data are not cleared, unwritten words read undefined
module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int TABLE_WORDS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write
  input  logic             cfg_wen,
  input  logic [PPN_W-1:0] cfg_wdata,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  walk_req_t        in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output walk_rsp_t        out_data
);

  ptw_cmd_t    cmd;
  ptw_status_t status;

  // sequencing: accept, walk steps, result transfer
  sv39ptw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // table store, walk registers and result register
  sv39ptw_dp #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
